[src/mqtt_hdr_pkg.sv]
// Shared types and constants for the MQTT fixed-header and PUBLISH parser.
`timescale 1ns / 1ps

package mqtt_hdr_pkg;

    // Parser phases
    localparam logic [2:0] PH_TYPE      = 3'd0;
    localparam logic [2:0] PH_LEN       = 3'd1;
    localparam logic [2:0] PH_TOPIC_LEN = 3'd2;
    localparam logic [2:0] PH_TOPIC     = 3'd3;
    localparam logic [2:0] PH_MSGID     = 3'd4;
    localparam logic [2:0] PH_BODY      = 3'd5;

    // Byte classes reported with each beat
    localparam logic [2:0] CLS_TYPE      = 3'd0;
    localparam logic [2:0] CLS_LEN       = 3'd1;
    localparam logic [2:0] CLS_TOPIC_LEN = 3'd2;
    localparam logic [2:0] CLS_TOPIC     = 3'd3;
    localparam logic [2:0] CLS_MSGID     = 3'd4;
    localparam logic [2:0] CLS_BODY      = 3'd5;

    // Control packet types
    localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
    localparam logic [3:0] TYPE_PUBACK   = 4'd4;
    localparam logic [3:0] TYPE_UNSUBACK = 4'd11;

    localparam int LEN_W = 28;

    // Result beat data, last field in the lowest bits
    typedef struct packed {
        logic              pad;
        logic [LEN_W-1:0]  payload_bytes;
        logic              id_present;
        logic [15:0]       packet_id;
        logic [15:0]       topic_length;
        logic [LEN_W-1:0]  remaining_length;
        logic [1:0]        qos_level;
        logic [3:0]        packet_type;
        logic [7:0]        echo_byte;
    } result_data_t;

    // Result beat side band, last field in the lowest bits
    typedef struct packed {
        logic       malformed;
        logic [2:0] byte_class;
    } result_user_t;

endpackage

[src/mqtt_header_parser_top.sv]
// MQTT fixed-header and PUBLISH parser: one stream byte in, one tagged result beat out.
// Output: a byte accepted at a clock edge is registered and appears as a result beat in the next cycle.
// Throughput: one byte per cycle unless m_tready stalls; the header state and the output register update together.
// The rate is set by the combinational state update (length digit add, field compares).
// Reset (aresetn low, synchronous): parser expects a type byte, all header state is zero,
// and the output register holds no beat.
`timescale 1ns / 1ps

module mqtt_header_parser_top #(
    parameter int MAX_LENGTH_DIGITS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] stream_byte
    input  logic                        s_tuser,   // [0] restart
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output mqtt_hdr_pkg::result_data_t  m_tdata,   // [7:0] echo_byte, [11:8] packet_type,
                                                   // [13:12] qos_level,
                                                   // [41:14] remaining_length,
                                                   // [57:42] topic_length,
                                                   // [73:58] packet_id, [74] id_present,
                                                   // [102:75] payload_bytes, [103] zero
    output mqtt_hdr_pkg::result_user_t  m_tuser,   // [2:0] byte_class, [3] malformed
    output logic                        m_tlast    // packet_end
);

    import mqtt_hdr_pkg::*;

    // Parser state
    logic [2:0]       phase_reg,      phase_next;
    logic [3:0]       type_reg,       type_next;
    logic [1:0]       qos_reg,        qos_next;
    logic [LEN_W-1:0] accum_reg,      accum_next;
    logic [2:0]       digits_reg,     digits_next;
    logic [LEN_W-1:0] left_reg,       left_next;
    logic [15:0]      topic_len_reg,  topic_len_next;
    logic [15:0]      topic_left_reg, topic_left_next;
    logic [15:0]      msg_id_reg,     msg_id_next;
    logic             half_reg,       half_next;
    logic             id_taken_reg,   id_taken_next;
    logic             tlen_done_reg,  tlen_done_next;

    // Output register
    logic             out_valid_reg;
    result_data_t     out_data_reg,   out_data_next;
    result_user_t     out_user_reg,   out_user_next;
    logic             out_last_reg,   out_last_next;

    logic             accept;
    logic [7:0]       in_byte;
    logic [2:0]       cur_phase;
    logic [2:0]       cls;
    logic             pkt_end;
    logic             bad;
    logic [LEN_W-1:0] digit_val;
    logic [LEN_W-1:0] left_dec;
    logic [15:0]      topic_left_dec;
    logic [LEN_W-1:0] id_len;
    logic [LEN_W-1:0] used;
    logic [LEN_W-1:0] pay_len;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign in_byte  = s_tdata;
    assign cur_phase = s_tuser ? PH_TYPE : phase_reg;

    // Place the seven digit bits at the weight of the current digit
    always_comb begin
        case (digits_reg[1:0])
            2'd0:    digit_val = LEN_W'(in_byte[6:0]);
            2'd1:    digit_val = LEN_W'(in_byte[6:0]) << 7;
            2'd2:    digit_val = LEN_W'(in_byte[6:0]) << 14;
            default: digit_val = LEN_W'(in_byte[6:0]) << 21;
        endcase
    end

    assign left_dec       = (left_reg != '0) ? left_reg - LEN_W'(1) : '0;
    assign topic_left_dec = (topic_left_reg != '0) ? topic_left_reg - 16'd1 : '0;
    assign id_len         = (qos_reg != 2'd0) ? LEN_W'(2) : '0;

    // Decode one byte against the held header state
    always_comb begin
        phase_next      = phase_reg;
        type_next       = type_reg;
        qos_next        = qos_reg;
        accum_next      = accum_reg;
        digits_next     = digits_reg;
        left_next       = left_reg;
        topic_len_next  = topic_len_reg;
        topic_left_next = topic_left_reg;
        msg_id_next     = msg_id_reg;
        half_next       = half_reg;
        id_taken_next   = id_taken_reg;
        tlen_done_next  = tlen_done_reg;
        cls             = CLS_TYPE;
        pkt_end         = 1'b0;
        bad             = 1'b0;

        unique case (cur_phase)
            PH_LEN: begin
                cls = CLS_LEN;
                if (digits_reg >= 3'(MAX_LENGTH_DIGITS)) begin
                    bad     = 1'b1;
                    pkt_end = 1'b1;
                end else begin
                    accum_next  = accum_reg + digit_val;
                    digits_next = digits_reg + 3'd1;
                    if (!in_byte[7]) begin
                        left_next = accum_next;
                        if (type_reg == TYPE_PUBLISH) begin
                            if (accum_next < ((qos_reg != 2'd0) ? LEN_W'(4) : LEN_W'(2))) begin
                                bad     = 1'b1;
                                pkt_end = 1'b1;
                            end else begin
                                phase_next = PH_TOPIC_LEN;
                            end
                        end else if (type_reg >= TYPE_PUBACK && type_reg <= TYPE_UNSUBACK) begin
                            if (accum_next < LEN_W'(2)) begin
                                bad     = 1'b1;
                                pkt_end = 1'b1;
                            end else begin
                                phase_next = PH_MSGID;
                            end
                        end else if (accum_next == '0) begin
                            pkt_end = 1'b1;
                        end else begin
                            phase_next = PH_BODY;
                        end
                    end
                end
            end
            PH_TOPIC_LEN: begin
                cls       = CLS_TOPIC_LEN;
                left_next = left_dec;
                if (!half_reg) begin
                    topic_len_next = {in_byte, 8'h00};
                    half_next      = 1'b1;
                end else begin
                    topic_len_next = {topic_len_reg[15:8], in_byte};
                    half_next      = 1'b0;
                    tlen_done_next = 1'b1;
                    if (LEN_W'(topic_len_next) + id_len > left_dec) begin
                        bad     = 1'b1;
                        pkt_end = 1'b1;
                    end else if (topic_len_next != '0) begin
                        topic_left_next = topic_len_next;
                        phase_next      = PH_TOPIC;
                    end else if (qos_reg != 2'd0) begin
                        phase_next = PH_MSGID;
                    end else if (left_dec == '0) begin
                        pkt_end = 1'b1;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_TOPIC: begin
                cls             = CLS_TOPIC;
                left_next       = left_dec;
                topic_left_next = topic_left_dec;
                if (topic_left_dec == '0) begin
                    if (qos_reg != 2'd0) begin
                        phase_next = PH_MSGID;
                    end else if (left_dec == '0) begin
                        pkt_end = 1'b1;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_MSGID: begin
                cls       = CLS_MSGID;
                left_next = left_dec;
                if (!half_reg) begin
                    msg_id_next = {in_byte, 8'h00};
                    half_next   = 1'b1;
                end else begin
                    msg_id_next   = {msg_id_reg[15:8], in_byte};
                    half_next     = 1'b0;
                    id_taken_next = 1'b1;
                    if (left_dec == '0) begin
                        pkt_end = 1'b1;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                cls       = CLS_BODY;
                left_next = left_dec;
                if (left_dec == '0) begin
                    pkt_end = 1'b1;
                end
            end
            default: begin
                // Type byte: start a fresh packet
                cls             = CLS_TYPE;
                type_next       = in_byte[7:4];
                qos_next        = in_byte[2:1];
                accum_next      = '0;
                digits_next     = 3'd0;
                left_next       = '0;
                topic_len_next  = '0;
                topic_left_next = '0;
                msg_id_next     = '0;
                half_next       = 1'b0;
                id_taken_next   = 1'b0;
                tlen_done_next  = 1'b0;
                phase_next      = PH_LEN;
            end
        endcase

        if (pkt_end) begin
            phase_next = PH_TYPE;
        end
    end

    // Payload length of a PUBLISH once its topic length is known
    assign used = LEN_W'(2) + LEN_W'(topic_len_next)
                + ((qos_next != 2'd0) ? LEN_W'(2) : LEN_W'(0));

    always_comb begin
        pay_len = '0;
        if (type_next == TYPE_PUBLISH && tlen_done_next && !bad && accum_next >= used) begin
            pay_len = accum_next - used;
        end
    end

    // Assemble the result beat
    always_comb begin
        out_data_next.pad              = 1'b0;
        out_data_next.payload_bytes    = pay_len;
        out_data_next.id_present       = id_taken_next;
        out_data_next.packet_id        = msg_id_next;
        out_data_next.topic_length     = topic_len_next;
        out_data_next.remaining_length = accum_next;
        out_data_next.qos_level        = qos_next;
        out_data_next.packet_type      = type_next;
        out_data_next.echo_byte        = in_byte;
        out_user_next.malformed        = bad;
        out_user_next.byte_class       = cls;
        out_last_next                  = pkt_end;
    end

    // Advance the parser state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_TYPE;
            type_reg       <= '0;
            qos_reg        <= '0;
            accum_reg      <= '0;
            digits_reg     <= '0;
            left_reg       <= '0;
            topic_len_reg  <= '0;
            topic_left_reg <= '0;
            msg_id_reg     <= '0;
            half_reg       <= 1'b0;
            id_taken_reg   <= 1'b0;
            tlen_done_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            type_reg       <= type_next;
            qos_reg        <= qos_next;
            accum_reg      <= accum_next;
            digits_reg     <= digits_next;
            left_reg       <= left_next;
            topic_len_reg  <= topic_len_next;
            topic_left_reg <= topic_left_next;
            msg_id_reg     <= msg_id_next;
            half_reg       <= half_next;
            id_taken_reg   <= id_taken_next;
            tlen_done_reg  <= tlen_done_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    // A malformed beat always closes its packet
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_user_reg.malformed |-> out_last_reg)
        else $error("malformed beat without packet end");

    // The digit counter never runs past the digit limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        digits_reg <= 3'(MAX_LENGTH_DIGITS))
        else $error("length digit count overrun");

    // After a packet ends the parser waits for a type byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && pkt_end |=> phase_reg == PH_TYPE)
        else $error("parser not back at type byte after packet end");

    // A message id is only reported complete for packet types that carry one
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.id_present |->
            (out_data_reg.packet_type >= TYPE_PUBLISH &&
             out_data_reg.packet_type <= TYPE_UNSUBACK))
        else $error("message id flagged for a type without one");
`endif

endmodule
